@@ src/assert_macros.svh @@
// Assertion macros used by the checker file i2rd_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define I2RD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define I2RD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/i2rd_pkg.sv @@
// Types, constants and helpers of the integer to radix digits block.
// No dependencies.
package i2rd_pkg;

  localparam int unsigned VALUE_BITS      = 31;
  localparam int unsigned RADIX_BITS      = 6;
  localparam int unsigned CHAR_BITS       = 8;
  localparam int unsigned DIGIT_BITS      = 6;
  localparam int unsigned VALUE_WIDTH_DEF = 31;
  localparam int unsigned MAX_DIGITS_DEF  = 31;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam logic [RADIX_BITS-1:0] RADIX_MIN    = 6'd2;
  localparam logic [RADIX_BITS-1:0] RADIX_MAX    = 6'd36;
  localparam logic [DIGIT_BITS-1:0] DEC_LIMIT    = 6'd10;
  localparam logic [CHAR_BITS-1:0]  CHAR_ZERO    = 8'd48;
  localparam logic [CHAR_BITS-1:0]  ALPHA_OFFSET = 8'd55;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [RADIX_BITS-1:0] radix;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_BITS-1:0] digit_char;
    logic                 last;
    logic                 bad_radix;
  } out_item_t;

  typedef enum logic [1:0] {
    KIND_BAD,
    KIND_ZERO,
    KIND_NUM
  } kind_e;

  typedef struct packed {
    kind_e    kind;
    in_item_t item;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FETCH,
    ST_EMIT
  } state_e;

  function automatic logic [CHAR_BITS-1:0] to_ascii(logic [DIGIT_BITS-1:0] d);
    logic [CHAR_BITS-1:0] w;
    w = CHAR_BITS'(d);
    return (d < DEC_LIMIT) ? (w + CHAR_ZERO) : (w + ALPHA_OFFSET);
  endfunction

endpackage

@@ src/i2rd_front.sv @@
// Front end: accepts input items and classifies them as bad radix, zero or number.
// Depends on i2rd_pkg.
module i2rd_front import i2rd_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  input  logic     queue_full_i,
  output logic     push_o,
  output job_t     job_o
);

  logic [VALUE_WIDTH-1:0] value_masked;
  logic                   radix_bad;

  assign value_masked = VALUE_WIDTH'(in_item_i.value);
  assign radix_bad    = (in_item_i.radix < RADIX_MIN) || (in_item_i.radix > RADIX_MAX);

  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

  always_comb begin
    job_o.item = in_item_i;
    if (radix_bad) begin
      job_o.kind = KIND_BAD;
    end else if (value_masked == '0) begin
      job_o.kind = KIND_ZERO;
    end else begin
      job_o.kind = KIND_NUM;
    end
  end

endmodule

@@ src/i2rd_queue.sv @@
// Short job queue between the front end and the back end.
// Depends on i2rd_pkg.
module i2rd_queue import i2rd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output logic full_o,
  output logic valid_o,
  output job_t job_o
);

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  job_t          mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign full_o  = (count_q == CW'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = mem[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= job_i;
    end
  end

endmodule

@@ src/i2rd_div.sv @@
// Restoring divider by the radix, one quotient bit per cycle.
// Depends on i2rd_pkg.
module i2rd_div import i2rd_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] dividend_i,
  input  logic [RADIX_BITS-1:0]  divisor_i,
  output logic                   done_o,
  output logic [VALUE_WIDTH-1:0] quotient_o,
  output logic [DIGIT_BITS-1:0]  remainder_o
);

  localparam int unsigned CW = $clog2(VALUE_WIDTH);

  logic                   busy_q;
  logic                   done_q;
  logic [CW-1:0]          cnt_q;
  logic [VALUE_WIDTH-1:0] quo_q;
  logic [DIGIT_BITS-1:0]  rem_q;
  logic [RADIX_BITS-1:0]  dvs_q;
  logic [DIGIT_BITS:0]    trial;
  logic [DIGIT_BITS:0]    diff;
  logic                   fits;

  assign trial = {rem_q, quo_q[VALUE_WIDTH-1]};
  assign fits  = (trial >= {1'b0, dvs_q});
  assign diff  = trial - {1'b0, dvs_q};

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(VALUE_WIDTH - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[VALUE_WIDTH-2:0], fits};
      rem_q <= fits ? diff[DIGIT_BITS-1:0] : trial[DIGIT_BITS-1:0];
    end
  end

endmodule

@@ src/i2rd_back.sv @@
// Back end: passes zero and bad-radix items straight out; for numbers it divides repeatedly,
// keeps the digits and emits them most significant first. Depends on i2rd_pkg and i2rd_div.
module i2rd_back import i2rd_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int unsigned MAX_DIGITS  = MAX_DIGITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  input  job_t      job_i,
  output logic      job_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned CNTW = $clog2(MAX_DIGITS + 1);
  localparam int unsigned AW   = $clog2(MAX_DIGITS);

  state_e                 state_q, state_d;
  logic [CNTW-1:0]        cnt_q, cnt_d;
  logic [RADIX_BITS-1:0]  radix_q;
  logic [DIGIT_BITS-1:0]  store [MAX_DIGITS];
  logic [DIGIT_BITS-1:0]  rd_q;
  logic                   wr_en;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_q, out_d;
  logic                   out_free;
  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend;
  logic [RADIX_BITS-1:0]  div_divisor;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quotient;
  logic [DIGIT_BITS-1:0]  div_rem;

  i2rd_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quotient),
    .remainder_o(div_rem)
  );

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign div_divisor = (state_q == ST_IDLE) ? job_i.item.radix : radix_q;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    job_pop_o    = 1'b0;
    div_start    = 1'b0;
    div_dividend = VALUE_WIDTH'(job_i.item.value);
    wr_en        = 1'b0;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;
    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          unique case (job_i.kind)
            KIND_BAD: begin
              if (out_free) begin
                job_pop_o        = 1'b1;
                out_valid_d      = 1'b1;
                out_d.digit_char = '0;
                out_d.last       = 1'b1;
                out_d.bad_radix  = 1'b1;
              end
            end
            KIND_ZERO: begin
              if (out_free) begin
                job_pop_o        = 1'b1;
                out_valid_d      = 1'b1;
                out_d.digit_char = CHAR_ZERO;
                out_d.last       = 1'b1;
                out_d.bad_radix  = 1'b0;
              end
            end
            KIND_NUM: begin
              job_pop_o = 1'b1;
              div_start = 1'b1;
              cnt_d     = '0;
              state_d   = ST_DIV;
            end
            default: begin
            end
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (cnt_q < CNTW'(MAX_DIGITS)) begin
            wr_en = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end
          if (div_quotient == '0) begin
            state_d = ST_FETCH;
          end else begin
            div_start    = 1'b1;
            div_dividend = div_quotient;
          end
        end
      end
      ST_FETCH: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.digit_char = to_ascii(rd_q);
          out_d.last       = (cnt_q == CNTW'(1));
          out_d.bad_radix  = 1'b0;
          cnt_d            = cnt_q - 1'b1;
          state_d          = (cnt_q == CNTW'(1)) ? ST_IDLE : ST_FETCH;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (state_q == ST_IDLE && job_pop_o) begin
      radix_q <= job_i.item.radix;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store[AW'(cnt_q)] <= div_rem;
    end
    rd_q <= store[AW'(cnt_q - 1'b1)];
  end

endmodule

@@ src/integer_to_radix_digits.sv @@
// Top level of the integer to radix digits converter.
// Depends on i2rd_pkg, i2rd_front, i2rd_queue and i2rd_back.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i/in_stall_o   | in_item_t  (value, radix)
//   out     | output    | out_valid_o/out_stall_i | out_item_t (digit_char, last, bad_radix)
//
// The time per number is set by the radix divider, one quotient bit per cycle, which runs
// once per digit, and then by the fetch and emit of each character.
// Zero and bad-radix items skip the divider and are emitted directly once the output is free.
// The two-entry job queue takes new items, until it is full, while the back end works or the output stalls.
// Reset clears the queue, the sequencer and the output valid; the digit store is not cleared.
module integer_to_radix_digits import i2rd_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int unsigned MAX_DIGITS  = MAX_DIGITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic push;
  job_t push_job;
  logic queue_full;
  logic queue_valid;
  job_t queue_job;
  logic pop;

  i2rd_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .queue_full_i(queue_full),
    .push_o      (push),
    .job_o       (push_job)
  );

  i2rd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .full_o (queue_full),
    .valid_o(queue_valid),
    .job_o  (queue_job)
  );

  i2rd_back #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(queue_valid),
    .job_i      (queue_job),
    .job_pop_o  (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule

@@ src/i2rd_checker.sv @@
// Port-level checks of the integer to radix digits converter, bound to the top level.
// Depends on i2rd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module i2rd_checker import i2rd_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  logic char_legal;
  logic in_wait;
  logic out_wait;
  logic bad_ok;

  assign char_legal = ((out_item_o.digit_char >= 8'd48) && (out_item_o.digit_char <= 8'd57))
                   || ((out_item_o.digit_char >= 8'd65) && (out_item_o.digit_char <= 8'd90));
  assign in_wait    = in_valid_i && in_stall_o;
  assign out_wait   = out_valid_o && out_stall_i;
  assign bad_ok     = out_item_o.last && (out_item_o.digit_char == '0);

  `I2RD_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_wait, in_valid_i && $stable(in_item_i), "input item not held")
  `I2RD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_wait, out_valid_o && $stable(out_item_o), "output not held")
  `I2RD_ASSERT_IMPL(a_bad_form, clk_i, rst_ni, out_valid_o && out_item_o.bad_radix, bad_ok, "bad radix malformed")
  `I2RD_ASSERT_IMPL(a_char_set, clk_i, rst_ni, out_valid_o && !out_item_o.bad_radix, char_legal, "bad character")

endmodule

bind integer_to_radix_digits i2rd_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_item_i  (in_item_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_item_o (out_item_o)
);
